[sv/tlc_pkg.sv]
package tlc_pkg;

	// Default geometry and fixed address split
	localparam int L1_WAYS_DEF = 8;
	localparam int L2_WAYS_DEF = 16;
	localparam int L1_SETS     = 128;
	localparam int L2_SETS     = 4096;
	localparam int OFF_W       = 6;
	localparam int L1_SET_W    = 7;
	localparam int L2_SET_W    = 12;
	localparam int L1_TAG_W    = 19;
	localparam int L2_TAG_W    = 14;
	localparam int RAND_W      = 32;

	localparam logic [31:0] SEED_RESET = 32'h3025_2471;

	localparam logic [7:0] COST_L1 = 8'd2;
	localparam logic [7:0] COST_L2 = 8'd10;
	localparam logic [7:0] COST_MEM = 8'd200;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;
		logic accept;
		logic draw_go;
		logic draw_l2;
		logic take_l1;
		logic take_l2;
		logic update;
		logic next_part;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic need_l1_draw;
		logic need_l2_draw;
		logic draw_ready;
		logic split_pending;
	} sts_t;

	// One step of the xorshift32 generator
	function automatic logic [31:0] xorshift(input logic [31:0] s);
		logic [31:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

[sv/tlc_ram.sv]
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[sv/tlc_ctrl.sv]
module tlc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tlc_pkg::sts_t sts,
	output tlc_pkg::ctl_t ctl
);
	import tlc_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_LOOK   = 3'd3;
	localparam logic [2:0] S_DRAW1  = 3'd4;
	localparam logic [2:0] S_DRAW2  = 3'd5;
	localparam logic [2:0] S_UPDATE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		ctl = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clear = 1'b1;
				if (sts.clear_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: state_nxt = S_LOOK;
			S_LOOK: begin
				if (sts.need_l1_draw) begin
					ctl.draw_go = 1'b1;
					state_nxt = S_DRAW1;
				end else if (sts.need_l2_draw) begin
					ctl.draw_go = 1'b1;
					ctl.draw_l2 = 1'b1;
					state_nxt = S_DRAW2;
				end else begin
					state_nxt = S_UPDATE;
				end
			end
			S_DRAW1: begin
				if (sts.draw_ready) begin
					ctl.take_l1 = 1'b1;
					if (sts.need_l2_draw) begin
						ctl.draw_go = 1'b1;
						ctl.draw_l2 = 1'b1;
						state_nxt = S_DRAW2;
					end else begin
						state_nxt = S_UPDATE;
					end
				end
			end
			S_DRAW2: begin
				if (sts.draw_ready) begin
					ctl.take_l2 = 1'b1;
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				ctl.update = 1'b1;
				if (sts.split_pending) begin
					ctl.next_part = 1'b1;
					state_nxt = S_READ;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

[sv/tlc_datapath.sv]
module tlc_datapath #(
	parameter int L1_WAYS = tlc_pkg::L1_WAYS_DEF,
	parameter int L2_WAYS = tlc_pkg::L2_WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tlc_pkg::ctl_t ctl,
	output tlc_pkg::sts_t sts,
	input  logic          command,
	input  logic [31:0]   address,
	input  logic [2:0]    length,
	input  logic          seed_valid,
	input  logic [31:0]   replacement_seed,
	output logic          strobe,
	output logic          l1_hit,
	output logic [9:0]    l1_line,
	output logic          l2_used,
	output logic          l2_hit,
	output logic [15:0]   l2_line,
	output logic          writeback_valid,
	output logic [31:0]   writeback_address,
	output logic [31:0]   refill_address,
	output logic [7:0]    cycles_added,
	output logic [63:0]   cycle_total,
	output logic          last
);
	import tlc_pkg::*;

	localparam int L1_WB = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
	localparam int L2_WB = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
	localparam int MAXW  = (L1_WAYS > L2_WAYS) ? L1_WAYS : L2_WAYS;
	localparam int RW    = $clog2(MAXW + 1);

	// Residues of the byte weights and reciprocals for the way counts
	localparam int          RK       = 20;
	localparam logic [4:0]  L1_R8    = 5'((1 << 8) % L1_WAYS);
	localparam logic [4:0]  L1_R16   = 5'((1 << 16) % L1_WAYS);
	localparam logic [4:0]  L1_R24   = 5'((1 << 24) % L1_WAYS);
	localparam logic [4:0]  L2_R8    = 5'((1 << 8) % L2_WAYS);
	localparam logic [4:0]  L2_R16   = 5'((1 << 16) % L2_WAYS);
	localparam logic [4:0]  L2_R24   = 5'((1 << 24) % L2_WAYS);
	localparam logic [20:0] L1_RECIP = 21'(((1 << RK) + L1_WAYS - 1) / L1_WAYS);
	localparam logic [20:0] L2_RECIP = 21'(((1 << RK) + L2_WAYS - 1) / L2_WAYS);

	// Current part of the transaction
	logic        cmd_q;
	logic [31:0] part_addr_q;
	logic        split_q;
	logic [7:0]  end_off;

	assign end_off = 8'(address[OFF_W-1:0]) + 8'(length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b0;
		end else if (ctl.accept) begin
			split_q <= (command == CMD_WRITE) && (end_off > 8'd64);
		end else if (ctl.next_part) begin
			split_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q       <= command;
			part_addr_q <= address;
		end else if (ctl.next_part) begin
			part_addr_q <= {part_addr_q[31:OFF_W], {OFF_W{1'b0}}} + 32'd64;
		end
	end

	logic                is_write;
	logic [L1_SET_W-1:0] l1_set;
	logic [L2_SET_W-1:0] l2_set;
	logic [L1_TAG_W-1:0] l1_tag;
	logic [L2_TAG_W-1:0] l2_tag;

	assign is_write = (cmd_q == CMD_WRITE);
	assign l1_set   = part_addr_q[OFF_W +: L1_SET_W];
	assign l2_set   = part_addr_q[OFF_W +: L2_SET_W];
	assign l1_tag   = part_addr_q[31 -: L1_TAG_W];
	assign l2_tag   = part_addr_q[31 -: L2_TAG_W];

	// Clear sweep over the valid rows after reset
	logic [L2_SET_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Tag and state memories, one row per set
	logic                         l1v_we, l1t_we, l2vd_we, l2t_we;
	logic [L1_SET_W-1:0]          l1v_waddr;
	logic [L2_SET_W-1:0]          l2vd_waddr;
	logic [L1_WAYS-1:0]           l1v_row, l1v_wrow;
	logic [L1_WAYS*L1_TAG_W-1:0]  l1t_row, l1t_wrow;
	logic [2*L2_WAYS-1:0]         l2vd_row, l2vd_wrow, l2vd_wdata;
	logic [L2_WAYS*L2_TAG_W-1:0]  l2t_row, l2t_wrow;
	logic [L1_WAYS-1:0]           l1v_wdata;

	tlc_ram #(.WIDTH(L1_WAYS), .DEPTH(L1_SETS)) u_l1v (
		.clk(clk), .we(l1v_we), .waddr(l1v_waddr), .wdata(l1v_wdata),
		.raddr(l1_set), .rdata(l1v_row)
	);
	tlc_ram #(.WIDTH(L1_WAYS*L1_TAG_W), .DEPTH(L1_SETS)) u_l1t (
		.clk(clk), .we(l1t_we), .waddr(l1_set), .wdata(l1t_wrow),
		.raddr(l1_set), .rdata(l1t_row)
	);
	tlc_ram #(.WIDTH(2*L2_WAYS), .DEPTH(L2_SETS)) u_l2vd (
		.clk(clk), .we(l2vd_we), .waddr(l2vd_waddr), .wdata(l2vd_wdata),
		.raddr(l2_set), .rdata(l2vd_row)
	);
	tlc_ram #(.WIDTH(L2_WAYS*L2_TAG_W), .DEPTH(L2_SETS)) u_l2t (
		.clk(clk), .we(l2t_we), .waddr(l2_set), .wdata(l2t_wrow),
		.raddr(l2_set), .rdata(l2t_row)
	);

	// L1 lookup: hit way and first free way
	logic             l1_hit_c, l1_full;
	logic [L1_WB-1:0] l1_hit_way, l1_free_way;

	always_comb begin
		l1_hit_c    = 1'b0;
		l1_hit_way  = '0;
		l1_free_way = '0;
		l1_full     = 1'b1;
		for (int i = L1_WAYS - 1; i >= 0; i--) begin
			if (l1v_row[i] && (l1t_row[i*L1_TAG_W +: L1_TAG_W] == l1_tag)) begin
				l1_hit_c   = 1'b1;
				l1_hit_way = L1_WB'(i);
			end
			if (!l1v_row[i]) begin
				l1_full     = 1'b0;
				l1_free_way = L1_WB'(i);
			end
		end
	end

	// L2 lookup
	logic             l2_hit_c, l2_full, l2_need;
	logic [L2_WB-1:0] l2_hit_way, l2_free_way;

	always_comb begin
		l2_hit_c    = 1'b0;
		l2_hit_way  = '0;
		l2_free_way = '0;
		l2_full     = 1'b1;
		for (int i = L2_WAYS - 1; i >= 0; i--) begin
			if (l2vd_row[i] && (l2t_row[i*L2_TAG_W +: L2_TAG_W] == l2_tag)) begin
				l2_hit_c   = 1'b1;
				l2_hit_way = L2_WB'(i);
			end
			if (!l2vd_row[i]) begin
				l2_full     = 1'b0;
				l2_free_way = L2_WB'(i);
			end
		end
	end

	assign l2_need = is_write || !l1_hit_c;

	// Victim generator; the draw is reduced modulo the way count by folding
	// its bytes with constant residues, then a reciprocal multiply
	logic [31:0]      rnd_q, rnd_nxt;
	logic [1:0]       cnt_q;
	logic             sel_l2_q;
	logic [4:0]       res8, res16, res24;
	logic [20:0]      recip;
	logic [5:0]       ways_m;
	logic [14:0]      fold_c, fold_s1, fold_s2, quot;
	logic [35:0]      prod_s2;
	logic [20:0]      quot_m;
	logic [RW-1:0]    rem_q;
	logic [L1_WB-1:0] l1_draw_q;
	logic [L2_WB-1:0] l2_draw_q;

	assign rnd_nxt = xorshift(rnd_q);
	assign res8    = sel_l2_q ? L2_R8 : L1_R8;
	assign res16   = sel_l2_q ? L2_R16 : L1_R16;
	assign res24   = sel_l2_q ? L2_R24 : L1_R24;
	assign recip   = sel_l2_q ? L2_RECIP : L1_RECIP;
	assign ways_m  = sel_l2_q ? 6'(L2_WAYS) : 6'(L1_WAYS);

	// Folded value stays below 2^15 and keeps the residue
	assign fold_c = 15'(rnd_q[7:0]) + 15'(rnd_q[15:8]) * 15'(res8)
		+ 15'(rnd_q[23:16]) * 15'(res16) + 15'(rnd_q[31:24]) * 15'(res24);
	assign quot   = 15'(prod_s2 >> RK);
	assign quot_m = 21'(quot) * 21'(ways_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= SEED_RESET;
			cnt_q <= '0;
		end else if (seed_valid) begin
			rnd_q <= replacement_seed;
		end else if (ctl.draw_go) begin
			rnd_q <= rnd_nxt;
			cnt_q <= 2'd3;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Three stages: fold, multiply, remainder
	always_ff @(posedge clk) begin
		if (ctl.draw_go) sel_l2_q <= ctl.draw_l2;
		fold_s1 <= fold_c;
		fold_s2 <= fold_s1;
		prod_s2 <= 36'(fold_s1) * 36'(recip);
		rem_q   <= RW'(fold_s2 - quot_m[14:0]);
		if (ctl.take_l1) l1_draw_q <= L1_WB'(rem_q);
		if (ctl.take_l2) l2_draw_q <= L2_WB'(rem_q);
	end

	// Final way choices
	logic [L1_WB-1:0] l1_way;
	logic [L2_WB-1:0] l2_way;
	logic             l1_fill;

	assign l1_fill = !is_write && !l1_hit_c;
	assign l1_way  = l1_hit_c ? l1_hit_way : (l1_full ? l1_draw_q : l1_free_way);
	assign l2_way  = l2_hit_c ? l2_hit_way : (l2_full ? l2_draw_q : l2_free_way);

	// New rows and victim fields
	logic [L2_TAG_W-1:0] vic_tag;
	logic                vic_dirty;

	always_comb begin
		l1v_wrow  = l1v_row;
		l1t_wrow  = l1t_row;
		l2vd_wrow = l2vd_row;
		l2t_wrow  = l2t_row;
		vic_tag   = '0;
		vic_dirty = 1'b0;
		for (int i = 0; i < L1_WAYS; i++) begin
			if (L1_WB'(i) == l1_way) begin
				l1v_wrow[i] = 1'b1;
				l1t_wrow[i*L1_TAG_W +: L1_TAG_W] = l1_tag;
			end
		end
		for (int i = 0; i < L2_WAYS; i++) begin
			if (L2_WB'(i) == l2_way) begin
				vic_tag   = l2t_row[i*L2_TAG_W +: L2_TAG_W];
				vic_dirty = l2vd_row[i] && l2vd_row[L2_WAYS + i];
				l2vd_wrow[i] = 1'b1;
				l2vd_wrow[L2_WAYS + i] = is_write || (l2_hit_c && l2vd_row[L2_WAYS + i]);
				l2t_wrow[i*L2_TAG_W +: L2_TAG_W] = l2_tag;
			end
		end
	end

	// Memory write ports; the valid and dirty ports are shared with the clear sweep
	assign l1v_we     = ctl.clear || (ctl.update && l1_fill);
	assign l1t_we     = ctl.update && l1_fill;
	assign l1v_waddr  = ctl.clear ? clr_q[L1_SET_W-1:0] : l1_set;
	assign l1v_wdata  = ctl.clear ? '0 : l1v_wrow;
	assign l2vd_we    = ctl.clear || (ctl.update && l2_need);
	assign l2t_we     = ctl.update && l2_need;
	assign l2vd_waddr = ctl.clear ? clr_q : l2_set;
	assign l2vd_wdata = ctl.clear ? '0 : l2vd_wrow;

	// Result register
	logic        strobe_q;
	logic [63:0] total_q;
	logic [7:0]  cost;
	logic [9:0]  l1_line_c;
	logic [15:0] l2_line_c;

	assign cost      = !l2_need ? COST_L1 : (l2_hit_c ? COST_L2 : COST_MEM);
	assign l1_line_c = (is_write && !l1_hit_c) ? 10'd0
		: 10'(32'(l1_set) * L1_WAYS + 32'(l1_way));
	assign l2_line_c = 16'(32'(l2_set) * L2_WAYS + 32'(l2_way));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			total_q  <= '0;
		end else begin
			strobe_q <= ctl.update;
			if (ctl.update) total_q <= total_q + 64'(cost);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			l1_hit            <= l1_hit_c;
			l1_line           <= l1_line_c;
			l2_used           <= l2_need;
			l2_hit            <= l2_need && l2_hit_c;
			l2_line           <= l2_need ? l2_line_c : 16'd0;
			writeback_valid   <= l2_need && !l2_hit_c && vic_dirty;
			writeback_address <= (l2_need && !l2_hit_c && vic_dirty)
				? {vic_tag, l2_set, {OFF_W{1'b0}}} : 32'd0;
			refill_address    <= (l2_need && !l2_hit_c)
				? {part_addr_q[31:OFF_W], {OFF_W{1'b0}}} : 32'd0;
			cycles_added      <= cost;
			last              <= !split_q;
		end
	end

	assign strobe      = strobe_q;
	assign cycle_total = total_q;

	// Status to the controller
	assign sts.clear_last    = (clr_q == {L2_SET_W{1'b1}});
	assign sts.need_l1_draw  = l1_fill && l1_full;
	assign sts.need_l2_draw  = l2_need && !l2_hit_c && l2_full;
	assign sts.draw_ready    = (cnt_q == '0);
	assign sts.split_pending = split_q;
endmodule

[sv/two_level_cache_tag_controller.sv]
// Flow: an accepted access passes the read, lookup and update states, and the
// result is registered from the update state; each random victim draw adds a wait
// in a draw state (xorshift step, residue fold, reciprocal multiply, remainder).
// A split write gives two results; the second part runs read, lookup and update
// again, plus draws. One transaction at a time; busy stays high until the last
// result. Reset: asynchronous; a sweep over all sets then clears the valid and dirty
// rows, with busy high. The receiver cannot stall; each result shows for one cycle.
module two_level_cache_tag_controller #(
	parameter int L1_WAYS = tlc_pkg::L1_WAYS_DEF,
	parameter int L2_WAYS = tlc_pkg::L2_WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] address,
	input  logic [2:0]  length,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] replacement_seed,
	output logic        strobe,
	output logic        l1_hit,
	output logic [9:0]  l1_line,
	output logic        l2_used,
	output logic        l2_hit,
	output logic [15:0] l2_line,
	output logic        writeback_valid,
	output logic [31:0] writeback_address,
	output logic [31:0] refill_address,
	output logic [7:0]  cycles_added,
	output logic [63:0] cycle_total,
	output logic        last
);
	import tlc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign seed_ready = 1'b1;

	tlc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .ctl(ctl)
	);

	tlc_datapath #(.L1_WAYS(L1_WAYS), .L2_WAYS(L2_WAYS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(command), .address(address), .length(length),
		.seed_valid(seed_valid), .replacement_seed(replacement_seed),
		.strobe(strobe), .l1_hit(l1_hit), .l1_line(l1_line),
		.l2_used(l2_used), .l2_hit(l2_hit), .l2_line(l2_line),
		.writeback_valid(writeback_valid), .writeback_address(writeback_address),
		.refill_address(refill_address), .cycles_added(cycles_added),
		.cycle_total(cycle_total), .last(last)
	);
endmodule

[sv/tlc_checker.sv]
module tlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic       l1_hit,
	input logic       l2_used,
	input logic       l2_hit,
	input logic       writeback_valid,
	input logic [7:0] cycles_added,
	input logic       last
);
	// A transaction keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");

	// Results never come back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("back-to-back results");

	// Cost matches the level that served the access
	a_cost: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (!l2_used && l1_hit && cycles_added == 8'd2)
			|| (l2_used && l2_hit && cycles_added == 8'd10)
			|| (l2_used && !l2_hit && cycles_added == 8'd200))
		else $error("cost does not match hit levels");

	// Write-back only on an L2 miss
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && writeback_valid |-> l2_used && !l2_hit)
		else $error("write-back without L2 miss");

	// A first part is followed while still busy
	a_part: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("split write dropped");
endmodule

bind two_level_cache_tag_controller tlc_checker u_tlc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.l1_hit(l1_hit), .l2_used(l2_used), .l2_hit(l2_hit),
	.writeback_valid(writeback_valid), .cycles_added(cycles_added), .last(last)
);

[sim/tb_two_level_cache_tag_controller.sv]
module tb_two_level_cache_tag_controller;
	import tlc_pkg::*;

	localparam int NL1W = 8;
	localparam int NL2W = 16;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] addr;
		logic [2:0]  len;
	} access_t;

	typedef struct packed {
		logic        l1_hit;
		logic [9:0]  l1_line;
		logic        l2_used;
		logic        l2_hit;
		logic [15:0] l2_line;
		logic        wb_valid;
		logic [31:0] wb_addr;
		logic [31:0] refill;
		logic [7:0]  cost;
		logic [63:0] total;
		logic        last;
	} cache_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = 1'b0;
	logic [31:0] address = '0;
	logic [2:0] length = '0;
	logic seed_valid = 1'b0;
	logic seed_ready;
	logic [31:0] seed_data = '0;
	logic strobe;
	logic l1_hit, l2_used, l2_hit, writeback_valid, last;
	logic [9:0] l1_line;
	logic [15:0] l2_line;
	logic [31:0] writeback_address, refill_address;
	logic [7:0] cycles_added;
	logic [63:0] cycle_total;

	// Shadow copy of the tag and policy state
	logic              l1_vld [NL1W*L1_SETS];
	logic [L1_TAG_W-1:0] l1_tag [NL1W*L1_SETS];
	logic              l2_vld [NL2W*L2_SETS];
	logic              l2_dty [NL2W*L2_SETS];
	logic [L2_TAG_W-1:0] l2_tag [NL2W*L2_SETS];
	logic [31:0] victim_rng;
	logic [63:0] charged_total;

	access_t       pending_accesses[$];
	cache_result_t expected_results[$];
	int            sender_idle_pct = 0;
	int            seed_writes = 0;
	int            error_count = 0;
	int            cycle_count = 0;

	two_level_cache_tag_controller u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .address(address), .length(length),
		.seed_valid(seed_valid), .seed_ready(seed_ready), .replacement_seed(seed_data),
		.strobe(strobe), .l1_hit(l1_hit), .l1_line(l1_line), .l2_used(l2_used),
		.l2_hit(l2_hit), .l2_line(l2_line), .writeback_valid(writeback_valid),
		.writeback_address(writeback_address), .refill_address(refill_address),
		.cycles_added(cycles_added), .cycle_total(cycle_total), .last(last)
	);

	always #1 clk = ~clk;

	// Next victim way from the shared xorshift generator
	function automatic int next_victim(input int ways);
		victim_rng = victim_rng ^ (victim_rng << 13);
		victim_rng = victim_rng ^ (victim_rng >> 17);
		victim_rng = victim_rng ^ (victim_rng << 5);
		return int'(victim_rng % ways);
	endfunction

	// L2 lookup with allocate; fills the L2 fields and the cost
	function automatic void l2_fetch(input logic [31:0] a, inout cache_result_t r);
		int set_i;
		int base;
		int w;
		int idx;
		logic [L2_TAG_W-1:0] t;
		set_i = int'(a[17:6]);
		base = set_i * NL2W;
		t = a[31:18];
		r.l2_used = 1'b1;
		for (w = 0; w < NL2W; w++) begin
			if (l2_vld[base+w] && l2_tag[base+w] == t) begin
				r.l2_hit = 1'b1;
				r.l2_line = 16'(base + w);
				r.cost = COST_L2;
				return;
			end
		end
		r.cost = COST_MEM;
		for (w = 0; w < NL2W; w++)
			if (!l2_vld[base+w])
				break;
		if (w == NL2W)
			w = next_victim(NL2W);
		idx = base + w;
		if (l2_vld[idx] && l2_dty[idx]) begin
			r.wb_valid = 1'b1;
			r.wb_addr = {l2_tag[idx], a[17:6], 6'd0};
		end
		r.refill = {a[31:6], 6'd0};
		l2_vld[idx] = 1'b1;
		l2_dty[idx] = 1'b0;
		l2_tag[idx] = t;
		r.l2_line = 16'(idx);
	endfunction

	function automatic int l1_match(input logic [31:0] a);
		int base;
		base = int'(a[12:6]) * NL1W;
		for (int w = 0; w < NL1W; w++)
			if (l1_vld[base+w] && l1_tag[base+w] == a[31:13])
				return base + w;
		return -1;
	endfunction

	function automatic void post_result(inout cache_result_t r, input logic is_last);
		charged_total = charged_total + 64'(r.cost);
		r.total = charged_total;
		r.last = is_last;
		expected_results.push_back(r);
	endfunction

	function automatic void write_part(input logic [31:0] a, input logic is_last);
		cache_result_t r;
		int hit_line;
		r = '0;
		hit_line = l1_match(a);
		if (hit_line >= 0) begin
			r.l1_hit = 1'b1;
			r.l1_line = 10'(hit_line);
		end
		l2_fetch(a, r);
		l2_dty[r.l2_line] = 1'b1;
		post_result(r, is_last);
	endfunction

	// Expected results of one accepted access
	function automatic void predict_access(input access_t x);
		cache_result_t r;
		int hit_line;
		int base;
		int w;
		logic [6:0] span;
		r = '0;
		if (x.cmd == CMD_READ) begin
			hit_line = l1_match(x.addr);
			if (hit_line >= 0) begin
				r.l1_hit = 1'b1;
				r.l1_line = 10'(hit_line);
				r.cost = COST_L1;
			end else begin
				base = int'(x.addr[12:6]) * NL1W;
				for (w = 0; w < NL1W; w++)
					if (!l1_vld[base+w])
						break;
				if (w == NL1W)
					w = next_victim(NL1W);
				l2_fetch(x.addr, r);
				l1_vld[base+w] = 1'b1;
				l1_tag[base+w] = x.addr[31:13];
				r.l1_line = 10'(base + w);
			end
			post_result(r, 1'b1);
		end else begin
			span = {1'b0, x.addr[5:0]} + 7'(x.len);
			if (span > 7'd64) begin
				write_part(x.addr, 1'b0);
				write_part(x.addr + 32'(7'd64 - {1'b0, x.addr[5:0]}), 1'b1);
			end else begin
				write_part(x.addr, 1'b1);
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// Driver: one access at a time, random sender gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (pending_accesses.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				access_t x;
				x = pending_accesses.pop_front();
				start <= 1'b1;
				command <= x.cmd;
				address <= x.addr;
				length <= x.len;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare results, then predict newly accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: l2_line %0h total %0h", l2_line, cycle_total);
					error_count++;
				end else begin
					cache_result_t e;
					e = expected_results.pop_front();
					check_field("l1_hit", e.l1_hit, l1_hit);
					check_field("l1_line", e.l1_line, l1_line);
					check_field("l2_used", e.l2_used, l2_used);
					check_field("l2_hit", e.l2_hit, l2_hit);
					check_field("l2_line", e.l2_line, l2_line);
					check_field("writeback_valid", e.wb_valid, writeback_valid);
					check_field("writeback_address", e.wb_addr, writeback_address);
					check_field("refill_address", e.refill, refill_address);
					check_field("cycles_added", e.cost, cycles_added);
					check_field("cycle_total", e.total, cycle_total);
					check_field("last", e.last, last);
				end
			end
			if (start && !busy)
				predict_access('{command, address, length});
			if (seed_valid && seed_ready) begin
				victim_rng = seed_data;
				seed_writes++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] pick_address();
		logic [13:0] t;
		logic [11:0] s;
		logic [5:0] o;
		if ($urandom_range(0, 99) < 25)
			return $urandom();
		// Crowd a few sets so that ways fill up and victims get drawn
		t = ($urandom_range(0, 3) == 0) ? 14'(14'h3ff0 + $urandom_range(0, 15))
			: 14'($urandom_range(0, 21));
		s = 12'($urandom_range(0, 3)) | (12'($urandom_range(0, 1)) << 11);
		o = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(58, 63)) : 6'($urandom());
		return {t, s, o};
	endfunction

	task automatic write_seed(input logic [31:0] v);
		int n;
		n = seed_writes;
		@(posedge clk);
		seed_valid <= 1'b1;
		seed_data <= v;
		wait (seed_writes > n);
		@(posedge clk);
		seed_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_accesses.size() > 0 || expected_results.size() > 0 || start || busy)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] seed_v, input int idle, input int count);
		access_t x;
		write_seed(seed_v);
		sender_idle_pct = idle;
		for (int i = 0; i < count; i++) begin
			x.cmd = 1'($urandom());
			x.addr = pick_address();
			x.len = 3'($urandom_range(0, 7));
			pending_accesses.push_back(x);
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < NL1W*L1_SETS; i++) begin
			l1_vld[i] = 1'b0;
			l1_tag[i] = '0;
		end
		for (int i = 0; i < NL2W*L2_SETS; i++) begin
			l2_vld[i] = 1'b0;
			l2_dty[i] = 1'b0;
			l2_tag[i] = '0;
		end
		victim_rng = SEED_RESET;
		charged_total = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: miss then hit, zero length, splits, address wrap, full sets
		pending_accesses.push_back('{CMD_READ, 32'h0000_0000, 3'd0});
		pending_accesses.push_back('{CMD_READ, 32'h0000_0000, 3'd0});
		pending_accesses.push_back('{CMD_WRITE, 32'h0000_0010, 3'd0});
		pending_accesses.push_back('{CMD_WRITE, 32'h0000_003e, 3'd4});
		pending_accesses.push_back('{CMD_WRITE, 32'h0000_007f, 3'd7});
		pending_accesses.push_back('{CMD_WRITE, 32'hffff_ffff, 3'd4});
		pending_accesses.push_back('{CMD_READ, 32'hffff_ffff, 3'd7});
		for (int k = 0; k < 17; k++)
			pending_accesses.push_back('{CMD_WRITE, (32'(k) << 18) | 32'h40, 3'd1});
		pending_accesses.push_back('{CMD_READ, 32'h0000_0040, 3'd0});
		sender_idle_pct = 0;
		drain();

		run_phase(32'hffff_ffff, 0, 300);
		run_phase(32'h0000_0001, 71, 300);
		run_phase(32'h0000_0000, 0, 200);
		run_phase($urandom(), 26, 300);
		run_phase(SEED_RESET, 0, 200);

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
sv/tlc_pkg.sv
sv/tlc_ram.sv
sv/tlc_ctrl.sv
sv/tlc_datapath.sv
sv/two_level_cache_tag_controller.sv
sv/tlc_checker.sv
sim/tb_two_level_cache_tag_controller.sv
